/* rtl/psinv_pkg.sv */
// Shared constants, command/status structs and state codes for the power series inverse block.
// Used by psinv_modmul, psinv_datapath, psinv_ctrl and power_series_inverse_mod.
// Depends on nothing else.
package psinv_pkg;

   // Longest series that the block holds.
   localparam int MaxTerms = 64;
   localparam int AddrW    = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
   localparam int CountW   = $clog2(MaxTerms + 1);

   // Field widths.
   localparam int DataW  = 30;
   localparam int TdataW = 32;
   localparam int RemW   = DataW + 2;
   localparam int ExpBitW = $clog2(DataW);

   // Modulus and the Fermat exponent.
   localparam logic [DataW-1:0] Prime     = 30'd1000000007;
   localparam logic [DataW-1:0] PrimeExp  = Prime - 30'd2;
   localparam logic [RemW-1:0]  PrimeRem  = {2'b00, Prime};
   localparam logic [RemW-1:0]  TwoPrime  = {1'b0, Prime, 1'b0};

   // Barrett factor floor(2^60 / P); it fits in 31 bits.
   localparam logic [63:0] BarrettWide = 64'h1000000000000000 / 64'd1000000007;
   localparam logic [DataW:0] BarrettMu = BarrettWide[DataW:0];

   typedef enum logic [1:0] {
      MUL_SQUARE,
      MUL_BASE,
      MUL_SCALE
   } mul_sel_type;

   typedef enum logic [1:0] {
      DST_NONE,
      DST_ACC,
      DST_POW,
      DST_INV
   } res_dst_type;

   typedef enum logic [12:0] {
      ST_LOAD         = 13'b0000000000001,
      ST_START        = 13'b0000000000010,
      ST_POW_SQ       = 13'b0000000000100,
      ST_POW_SQ_WAIT  = 13'b0000000001000,
      ST_POW_MUL      = 13'b0000000010000,
      ST_POW_MUL_WAIT = 13'b0000000100000,
      ST_POW_DONE     = 13'b0000001000000,
      ST_CONV         = 13'b0000010000000,
      ST_CONV_WAIT    = 13'b0000100000000,
      ST_SCALE        = 13'b0001000000000,
      ST_SCALE_WAIT   = 13'b0010000000000,
      ST_EMIT_RD      = 13'b0100000000000,
      ST_EMIT_LD      = 13'b1000000000000
   } state_type;

   typedef struct packed {
      logic             ser_wr;
      logic [AddrW-1:0] ser_waddr;
      logic             conv_rd;
      logic [AddrW-1:0] ser_raddr;
      logic             inv_ren;
      logic [AddrW-1:0] inv_raddr;
      logic             inv0_wr;
      logic [AddrW-1:0] inv_waddr;
      logic             acc_clr;
      logic             mul_go;
      mul_sel_type      mul_sel;
      res_dst_type      res_dst;
      logic             pow_init;
      logic             lead_set;
      logic             out_load;
      logic             out_last;
      logic             out_zero;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_idle;
      logic lead_zero;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/psinv_modmul.sv */
// Four-stage pipelined modular multiplier for the prime 1000000007 (Barrett reduction).
// Depends on psinv_pkg.
module psinv_modmul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [psinv_pkg::DataW-1:0] op_a,
   input  logic [psinv_pkg::DataW-1:0] op_b,
   output logic                       res_valid,
   output logic [psinv_pkg::DataW-1:0] res,
   output logic                       busy
);

   localparam int ProdW = 2 * psinv_pkg::DataW;
   localparam int MuW   = 2 * psinv_pkg::DataW + 2;
   localparam int QpW   = 2 * psinv_pkg::DataW + 1;

   logic                          v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic [ProdW-1:0]              x1_ff, x1_in;
   logic [MuW-1:0]                t2_ff, t2_in;
   logic [psinv_pkg::RemW-1:0]    xlo2_ff, xlo2_in, xlo3_ff, xlo3_in;
   logic [psinv_pkg::RemW-1:0]    qp3_ff, qp3_in;
   logic [psinv_pkg::DataW-1:0]   r4_ff, r4_in;
   logic [psinv_pkg::DataW:0]     x_hi;
   logic [psinv_pkg::DataW:0]     q_est;
   logic [QpW-1:0]                qp_full;
   logic [psinv_pkg::RemW-1:0]    diff;

   always_comb begin
      v1_in = in_valid;
      v2_in = v1_ff;
      v3_in = v2_ff;
      v4_in = v3_ff;

      // Full product.
      x1_in = ProdW'(op_a) * ProdW'(op_b);

      // Quotient estimate: (x >> (k-1)) * mu >> (k+1).
      x_hi    = x1_ff[ProdW-1:psinv_pkg::DataW-1];
      t2_in   = MuW'(x_hi) * MuW'(psinv_pkg::BarrettMu);
      xlo2_in = x1_ff[psinv_pkg::RemW-1:0];

      q_est   = t2_ff[MuW-1:psinv_pkg::DataW+1];
      qp_full = QpW'(q_est) * QpW'(psinv_pkg::Prime);
      qp3_in  = qp_full[psinv_pkg::RemW-1:0];
      xlo3_in = xlo2_ff;

      // The estimate is short by at most two multiples of P.
      diff = xlo3_ff - qp3_ff;
      if (diff >= psinv_pkg::TwoPrime) begin
         r4_in = psinv_pkg::DataW'(diff - psinv_pkg::TwoPrime);
      end else if (diff >= psinv_pkg::PrimeRem) begin
         r4_in = psinv_pkg::DataW'(diff - psinv_pkg::PrimeRem);
      end else begin
         r4_in = diff[psinv_pkg::DataW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff   <= x1_in;
      t2_ff   <= t2_in;
      xlo2_ff <= xlo2_in;
      qp3_ff  <= qp3_in;
      xlo3_ff <= xlo3_in;
      r4_ff   <= r4_in;
   end

   assign res_valid = v4_ff;
   assign res       = r4_ff;
   assign busy      = v1_ff | v2_ff | v3_ff | v4_ff;

endmodule

/* rtl/psinv_datapath.sv */
// Datapath: coefficient and inverse stores, the modular multiplier, accumulator,
// exponentiation register and the result output register.
// Depends on psinv_pkg and psinv_modmul.
module psinv_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  psinv_pkg::dp_cmd_type        cmd,
   output psinv_pkg::dp_status_type     status,
   input  logic [psinv_pkg::DataW-1:0]  req_coef,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [psinv_pkg::TdataW-1:0] rsp_tdata,
   output logic                         rsp_tlast,
   output logic                         rsp_tuser
);

   logic [psinv_pkg::DataW-1:0] series_mem  [psinv_pkg::MaxTerms];
   logic [psinv_pkg::DataW-1:0] inverse_mem [psinv_pkg::MaxTerms];

   logic [psinv_pkg::DataW-1:0] ser_rd_ff, inv_rd_ff;
   logic [psinv_pkg::DataW-1:0] coef_red;
   logic [psinv_pkg::DataW-1:0] lead_ff, lead_in;
   logic [psinv_pkg::DataW-1:0] lead_inv_ff, lead_inv_in;
   logic [psinv_pkg::DataW-1:0] pow_ff, pow_in;
   logic [psinv_pkg::DataW-1:0] acc_ff, acc_in;
   logic                        conv_pend_ff, conv_pend_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [psinv_pkg::DataW-1:0] rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_zero_ff, rsp_zero_in;
   logic                        inv_wr;
   logic [psinv_pkg::DataW-1:0] inv_wdata;
   logic                        mul_valid, mul_res_valid, mul_busy;
   logic [psinv_pkg::DataW-1:0] mul_a, mul_b, mul_res;

   function automatic logic [psinv_pkg::DataW-1:0] mod_add(
      input logic [psinv_pkg::DataW-1:0] x,
      input logic [psinv_pkg::DataW-1:0] y
   );
      logic [psinv_pkg::DataW:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, psinv_pkg::Prime}) begin
         s = s - {1'b0, psinv_pkg::Prime};
      end
      return s[psinv_pkg::DataW-1:0];
   endfunction

   function automatic logic [psinv_pkg::DataW-1:0] mod_neg(
      input logic [psinv_pkg::DataW-1:0] x
   );
      logic [psinv_pkg::DataW-1:0] r;
      r = (x == '0) ? '0 : psinv_pkg::Prime - x;
      return r;
   endfunction

   // Coefficients are below 2^30 < 2P, so one subtraction reduces them.
   assign coef_red = (req_coef >= psinv_pkg::Prime) ? req_coef - psinv_pkg::Prime : req_coef;

   always_ff @(posedge clock) begin
      if (cmd.ser_wr) begin
         series_mem[cmd.ser_waddr] <= coef_red;
      end
      if (cmd.conv_rd) begin
         ser_rd_ff <= series_mem[cmd.ser_raddr];
      end
   end

   assign inv_wr    = cmd.inv0_wr | (mul_res_valid && cmd.res_dst == psinv_pkg::DST_INV);
   assign inv_wdata = cmd.inv0_wr ? pow_ff : mod_neg(mul_res);

   always_ff @(posedge clock) begin
      if (inv_wr) begin
         inverse_mem[cmd.inv_waddr] <= inv_wdata;
      end
      if (cmd.inv_ren) begin
         inv_rd_ff <= inverse_mem[cmd.inv_raddr];
      end
   end

   // Convolution operands are the registered store reads and arrive in the cycle after the read.
   always_comb begin
      mul_a = ser_rd_ff;
      mul_b = inv_rd_ff;
      if (!conv_pend_ff) begin
         case (cmd.mul_sel)
            psinv_pkg::MUL_SQUARE: begin
               mul_a = pow_ff;
               mul_b = pow_ff;
            end
            psinv_pkg::MUL_BASE: begin
               mul_a = pow_ff;
               mul_b = lead_ff;
            end
            psinv_pkg::MUL_SCALE: begin
               mul_a = acc_ff;
               mul_b = lead_inv_ff;
            end
            default: begin
               mul_a = pow_ff;
               mul_b = pow_ff;
            end
         endcase
      end
   end

   assign mul_valid = conv_pend_ff | cmd.mul_go;

   psinv_modmul u_modmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .op_a      (mul_a),
      .op_b      (mul_b),
      .res_valid (mul_res_valid),
      .res       (mul_res),
      .busy      (mul_busy)
   );

   always_comb begin
      conv_pend_in = cmd.conv_rd;

      lead_in = lead_ff;
      if (cmd.ser_wr && cmd.ser_waddr == '0) begin
         lead_in = coef_red;
      end

      acc_in = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (mul_res_valid && cmd.res_dst == psinv_pkg::DST_ACC) begin
         acc_in = mod_add(acc_ff, mul_res);
      end

      pow_in = pow_ff;
      if (cmd.pow_init) begin
         pow_in = psinv_pkg::DataW'(1);
      end else if (mul_res_valid && cmd.res_dst == psinv_pkg::DST_POW) begin
         pow_in = mul_res;
      end

      lead_inv_in = cmd.lead_set ? pow_ff : lead_inv_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_zero_in  = rsp_zero_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cmd.out_zero ? '0 : inv_rd_ff;
         rsp_last_in  = cmd.out_last;
         rsp_zero_in  = cmd.out_zero;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         conv_pend_ff <= conv_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lead_ff     <= lead_in;
      acc_ff      <= acc_in;
      pow_ff      <= pow_in;
      lead_inv_ff <= lead_inv_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign status.mul_idle  = !(mul_busy | conv_pend_ff);
   assign status.lead_zero = (lead_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = psinv_pkg::TdataW'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_zero_ff;

   a_mul_reduced: assert property (@(posedge clock) disable iff (reset)
      mul_res_valid |-> mul_res < psinv_pkg::Prime)
      else $error("modular product not fully reduced");

   a_zero_flag_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_zero_ff |-> rsp_data_ff == '0)
      else $error("not-invertible result carries nonzero data");

   a_conv_no_overlap: assert property (@(posedge clock) disable iff (reset)
      conv_pend_ff |-> !cmd.mul_go)
      else $error("multiplier issue collides with a convolution product");

endmodule

/* rtl/psinv_ctrl.sv */
// Controller state machine: load counting, Fermat exponentiation sequence,
// per-term convolution sequencing and result emission.
// Depends on psinv_pkg.
module psinv_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tlast,
   output logic                     req_tready,
   output psinv_pkg::dp_cmd_type    cmd,
   input  psinv_pkg::dp_status_type status
);

   psinv_pkg::state_type               state_ff, state_in;
   logic [psinv_pkg::CountW-1:0]       count_ff, count_in;
   logic [psinv_pkg::CountW-1:0]       n_ff, n_in;
   logic [psinv_pkg::AddrW-1:0]        i_ff, i_in, k_ff, k_in, j_ff, j_in;
   logic [psinv_pkg::ExpBitW-1:0]      bit_ff, bit_in;
   logic                               zero_ff, zero_in;
   logic                               accept, has_room, i_last, j_last;

   assign req_tready = (state_ff == psinv_pkg::ST_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign has_room   = count_ff < psinv_pkg::CountW'(psinv_pkg::MaxTerms);
   assign i_last     = (psinv_pkg::CountW'(i_ff) + psinv_pkg::CountW'(1)) == n_ff;
   assign j_last     = (psinv_pkg::CountW'(j_ff) + psinv_pkg::CountW'(1)) == n_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      bit_in   = bit_ff;
      zero_in  = zero_ff;
      cmd      = '0;

      case (state_ff)
         psinv_pkg::ST_LOAD: begin
            cmd.ser_waddr = count_ff[psinv_pkg::AddrW-1:0];
            if (accept) begin
               cmd.ser_wr = has_room;
               if (req_tlast) begin
                  n_in     = has_room ? count_ff + psinv_pkg::CountW'(1) : count_ff;
                  count_in = '0;
                  state_in = psinv_pkg::ST_START;
               end else if (has_room) begin
                  count_in = count_ff + psinv_pkg::CountW'(1);
               end
            end
         end
         psinv_pkg::ST_START: begin
            j_in    = '0;
            zero_in = status.lead_zero;
            if (status.lead_zero) begin
               state_in = psinv_pkg::ST_EMIT_RD;
            end else begin
               cmd.pow_init = 1'b1;
               bit_in       = psinv_pkg::ExpBitW'(psinv_pkg::DataW - 1);
               state_in     = psinv_pkg::ST_POW_SQ;
            end
         end
         psinv_pkg::ST_POW_SQ: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = psinv_pkg::MUL_SQUARE;
            cmd.res_dst = psinv_pkg::DST_POW;
            state_in    = psinv_pkg::ST_POW_SQ_WAIT;
         end
         psinv_pkg::ST_POW_SQ_WAIT: begin
            cmd.res_dst = psinv_pkg::DST_POW;
            if (status.mul_idle) begin
               if (psinv_pkg::PrimeExp[bit_ff]) begin
                  state_in = psinv_pkg::ST_POW_MUL;
               end else if (bit_ff == '0) begin
                  state_in = psinv_pkg::ST_POW_DONE;
               end else begin
                  bit_in   = bit_ff - psinv_pkg::ExpBitW'(1);
                  state_in = psinv_pkg::ST_POW_SQ;
               end
            end
         end
         psinv_pkg::ST_POW_MUL: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = psinv_pkg::MUL_BASE;
            cmd.res_dst = psinv_pkg::DST_POW;
            state_in    = psinv_pkg::ST_POW_MUL_WAIT;
         end
         psinv_pkg::ST_POW_MUL_WAIT: begin
            cmd.res_dst = psinv_pkg::DST_POW;
            if (status.mul_idle) begin
               if (bit_ff == '0) begin
                  state_in = psinv_pkg::ST_POW_DONE;
               end else begin
                  bit_in   = bit_ff - psinv_pkg::ExpBitW'(1);
                  state_in = psinv_pkg::ST_POW_SQ;
               end
            end
         end
         psinv_pkg::ST_POW_DONE: begin
            cmd.lead_set  = 1'b1;
            cmd.inv0_wr   = 1'b1;
            cmd.inv_waddr = '0;
            i_in          = psinv_pkg::AddrW'(1);
            k_in          = psinv_pkg::AddrW'(1);
            if (n_ff == psinv_pkg::CountW'(1)) begin
               state_in = psinv_pkg::ST_EMIT_RD;
            end else begin
               state_in = psinv_pkg::ST_CONV;
            end
         end
         psinv_pkg::ST_CONV: begin
            // One product b[k] * r[i-k] enters the multiplier each cycle.
            cmd.conv_rd   = 1'b1;
            cmd.inv_ren   = 1'b1;
            cmd.ser_raddr = k_ff;
            cmd.inv_raddr = i_ff - k_ff;
            cmd.acc_clr   = (k_ff == psinv_pkg::AddrW'(1));
            cmd.res_dst   = psinv_pkg::DST_ACC;
            if (k_ff == i_ff) begin
               state_in = psinv_pkg::ST_CONV_WAIT;
            end else begin
               k_in = k_ff + psinv_pkg::AddrW'(1);
            end
         end
         psinv_pkg::ST_CONV_WAIT: begin
            cmd.res_dst = psinv_pkg::DST_ACC;
            if (status.mul_idle) begin
               state_in = psinv_pkg::ST_SCALE;
            end
         end
         psinv_pkg::ST_SCALE: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = psinv_pkg::MUL_SCALE;
            cmd.res_dst = psinv_pkg::DST_INV;
            state_in    = psinv_pkg::ST_SCALE_WAIT;
         end
         psinv_pkg::ST_SCALE_WAIT: begin
            cmd.res_dst   = psinv_pkg::DST_INV;
            cmd.inv_waddr = i_ff;
            if (status.mul_idle) begin
               if (i_last) begin
                  state_in = psinv_pkg::ST_EMIT_RD;
               end else begin
                  i_in     = i_ff + psinv_pkg::AddrW'(1);
                  k_in     = psinv_pkg::AddrW'(1);
                  state_in = psinv_pkg::ST_CONV;
               end
            end
         end
         psinv_pkg::ST_EMIT_RD: begin
            cmd.inv_ren   = 1'b1;
            cmd.inv_raddr = j_ff;
            state_in      = psinv_pkg::ST_EMIT_LD;
         end
         psinv_pkg::ST_EMIT_LD: begin
            cmd.out_last = j_last;
            cmd.out_zero = zero_ff;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (j_last) begin
                  state_in = psinv_pkg::ST_LOAD;
               end else begin
                  j_in     = j_ff + psinv_pkg::AddrW'(1);
                  state_in = psinv_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = psinv_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psinv_pkg::ST_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      i_ff    <= i_in;
      k_ff    <= k_in;
      j_ff    <= j_in;
      bit_ff  <= bit_in;
      zero_ff <= zero_in;
   end

   a_go_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_go |-> status.mul_idle)
      else $error("multiplier issued while products are still in flight");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output register overwritten before it was taken");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= psinv_pkg::CountW'(psinv_pkg::MaxTerms))
      else $error("coefficient count exceeds store depth");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> !req_tready && count_ff == '0)
      else $error("load did not close on the last coefficient");

endmodule

/* rtl/power_series_inverse_mod.sv */
// Power series inverse modulo 1000000007: coefficients b[0..n-1] stream in, one
// per transaction, lowest degree first, with req_tlast on the final one (at most
// 64 are kept; further ones, even the last, are dropped; values of P and above
// are reduced). After the last coefficient the block computes r with
// b*r = 1 mod x^n and returns r[0..n-1] in order, rsp_tlast on r[n-1]. r[0] is
// b[0]^(P-2), found by square-and-multiply on a four-stage pipelined Barrett
// multiplier: 45 dependent multiplies (30 squarings and 15 multiplies by b[0]).
// Each later term r[i] is -r[0] * sum b[k]*r[i-k], with one product entering the
// multiplier per cycle, then a drain and a scaling multiply. Results then leave
// one at a time, each read from the inverse store and then loaded into the output
// register, which holds its result while rsp_tready is low.
// A zero b[0] skips all arithmetic and returns n zeros with rsp_tuser set.
// Input is accepted only while loading; the next series may start loading as soon
// as the last result sits in the output register. Depends on psinv_pkg,
// psinv_ctrl and psinv_datapath.
module power_series_inverse_mod (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [psinv_pkg::TdataW-1:0] req_tdata,  // [29:0] coefficient, [31:30] zero
   input  logic                         req_tlast,  // last coefficient of the series
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [psinv_pkg::TdataW-1:0] rsp_tdata,  // [29:0] inverse_coefficient, [31:30] zero
   output logic                         rsp_tlast,  // final_res
   output logic                         rsp_tuser   // [0] not_invertible
);

   psinv_pkg::dp_cmd_type    cmd;
   psinv_pkg::dp_status_type status;

   // The controller sequences every phase; the datapath only executes commands.
   psinv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // The upper two tdata bits are padding and are ignored.
   psinv_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_coef   (req_tdata[psinv_pkg::DataW-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
